>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL files; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/hlcd_pkg.sv
// ----------------------------------------------------------------------------
// hlcd_pkg
// Types, codes and defaults shared by the deframer modules.
// ----------------------------------------------------------------------------
package hlcd_pkg;

    localparam int LENGTH_BITS_DEF     = 16;
    localparam int TICK_COUNT_BITS_DEF = 16;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int FRAME_LEN_BITS = 16;

    localparam logic [15:0] TIMEOUT_RESET = 16'd250;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HEADER_ONE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEADER_TWO   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEADER_THREE = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT      = 2'd3;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_GOOD      = 3'd1,
        KIND_SUM_BAD   = 3'd2,
        KIND_LEN_BAD   = 3'd3,
        KIND_TIMEOUT   = 3'd4
    } t_kind;

    typedef enum logic [7:0] {
        PH_HEAD1  = 8'b0000_0001,
        PH_HEAD2  = 8'b0000_0010,
        PH_HEAD3  = 8'b0000_0100,
        PH_LEN1   = 8'b0000_1000,
        PH_LEN2   = 8'b0001_0000,
        PH_LENCHK = 8'b0010_0000,
        PH_DATA   = 8'b0100_0000,
        PH_SUM    = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_kind                     kind;
        logic [7:0]                data;
        logic                      last;
        logic [FRAME_LEN_BITS-1:0] length;
    } t_result;

    typedef struct packed {
        logic                     we;
        logic [CFG_IDX_BITS-1:0]  addr;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

endpackage

>>> rtl/hlcd_parser.sv
// ----------------------------------------------------------------------------
// hlcd_parser
// Configuration registers, frame state machine and per-beat result logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hlcd_parser #(
    parameter int LENGTH_BITS     = 16,
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hlcd_pkg::t_cfg_wr i_cfg,
    input  logic              i_beat,
    input  logic              i_func,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output hlcd_pkg::t_result o_res
);
    import hlcd_pkg::*;

    localparam int CMP_BITS = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;

    logic [7:0]                 r_hdr1, r_hdr2, r_hdr3;
    logic [15:0]                r_timeout;
    t_phase                     r_phase, n_phase;
    logic [7:0]                 r_len_high, n_len_high;
    logic [LENGTH_BITS-1:0]     r_len, n_len;
    logic [7:0]                 r_len_sum, n_len_sum;
    logic [7:0]                 r_pay_sum, n_pay_sum;
    logic [LENGTH_BITS-1:0]     r_rcvd, n_rcvd;
    logic [TICK_COUNT_BITS-1:0] r_idle, n_idle;

    logic [TICK_COUNT_BITS-1:0] idle_inc;
    logic [LENGTH_BITS-1:0]     rcvd_inc;
    logic                       begun;
    logic                       res_valid;
    t_kind                      res_kind;
    logic [7:0]                 res_data;
    logic                       res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr1    <= 8'd0;
            r_hdr2    <= 8'd0;
            r_hdr3    <= 8'd0;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.addr)
                CFG_HEADER_ONE:   r_hdr1    <= i_cfg.data[7:0];
                CFG_HEADER_TWO:   r_hdr2    <= i_cfg.data[7:0];
                CFG_HEADER_THREE: r_hdr3    <= i_cfg.data[7:0];
                CFG_TIMEOUT:      r_timeout <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    assign idle_inc = (r_idle == '1) ? r_idle : r_idle + 1'b1;
    assign rcvd_inc = r_rcvd + 1'b1;
    assign begun    = ((r_phase == PH_DATA) && (r_rcvd != '0)) ||
                      ((r_phase == PH_SUM) && (r_len != '0));

    always_comb begin
        n_phase    = r_phase;
        n_len_high = r_len_high;
        n_len      = r_len;
        n_len_sum  = r_len_sum;
        n_pay_sum  = r_pay_sum;
        n_rcvd     = r_rcvd;
        n_idle     = r_idle;
        res_valid  = 1'b0;
        res_kind   = KIND_PAYLOAD;
        res_data   = 8'd0;
        res_last   = 1'b0;
        if (i_beat && (i_func == FUNC_TICK)) begin
            if (r_phase != PH_HEAD1) begin
                if (CMP_BITS'(idle_inc) < CMP_BITS'(r_timeout)) begin
                    n_idle = idle_inc;
                end else begin
                    n_idle    = '0;
                    n_phase   = PH_HEAD1;
                    res_valid = begun;
                    res_kind  = KIND_TIMEOUT;
                end
            end
        end else if (i_beat) begin
            n_idle = '0;
            case (r_phase)
                PH_HEAD1: begin
                    if (i_byte == r_hdr1) n_phase = PH_HEAD2;
                end
                PH_HEAD2: begin
                    n_phase = (i_byte == r_hdr2) ? PH_HEAD3 : PH_HEAD1;
                end
                PH_HEAD3: begin
                    if (i_byte == r_hdr3) begin
                        n_len_sum = 8'd0;
                        n_phase   = PH_LEN1;
                    end else begin
                        n_phase = PH_HEAD1;
                    end
                end
                PH_LEN1: begin
                    n_len_high = i_byte;
                    n_len_sum  = r_len_sum + i_byte;
                    n_phase    = PH_LEN2;
                end
                PH_LEN2: begin
                    n_len_sum = r_len_sum + i_byte;
                    n_len     = LENGTH_BITS'({r_len_high, i_byte});
                    n_phase   = PH_LENCHK;
                end
                PH_LENCHK: begin
                    if (i_byte == r_len_sum) begin
                        n_pay_sum = 8'd0;
                        n_rcvd    = '0;
                        n_phase   = (r_len == '0) ? PH_SUM : PH_DATA;
                    end else begin
                        n_phase   = PH_HEAD1;
                        res_valid = 1'b1;
                        res_kind  = KIND_LEN_BAD;
                    end
                end
                PH_DATA: begin
                    n_pay_sum = r_pay_sum + i_byte;
                    n_rcvd    = rcvd_inc;
                    res_last  = (rcvd_inc >= r_len);
                    if (res_last) n_phase = PH_SUM;
                    res_valid = 1'b1;
                    res_kind  = KIND_PAYLOAD;
                    res_data  = i_byte;
                end
                PH_SUM: begin
                    n_phase   = PH_HEAD1;
                    res_valid = 1'b1;
                    res_kind  = (i_byte == r_pay_sum) ? KIND_GOOD : KIND_SUM_BAD;
                end
                default: begin
                    n_phase = PH_HEAD1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEAD1;
            r_len_high <= 8'd0;
            r_len      <= '0;
            r_len_sum  <= 8'd0;
            r_pay_sum  <= 8'd0;
            r_rcvd     <= '0;
            r_idle     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_len_high <= n_len_high;
            r_len      <= n_len;
            r_len_sum  <= n_len_sum;
            r_pay_sum  <= n_pay_sum;
            r_rcvd     <= n_rcvd;
            r_idle     <= n_idle;
        end
    end

    assign o_res_valid = res_valid;
    assign o_res       = '{kind: res_kind, data: res_data, last: res_last,
                           length: FRAME_LEN_BITS'(r_len)};

    `ASSERT_IMPLIES(a_rcvd_in_range, i_clk, i_rst_n, r_phase == PH_DATA, r_rcvd < r_len)
    `ASSERT_IMPLIES(a_verdict_from_sum, i_clk, i_rst_n,
        res_valid && (res_kind == KIND_GOOD || res_kind == KIND_SUM_BAD), r_phase == PH_SUM)

endmodule

>>> rtl/hlcd_out_stage.sv
// ----------------------------------------------------------------------------
// hlcd_out_stage
// Output register with a skid slot; parts the input and output handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hlcd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_beat,
    input  logic              i_res_valid,
    input  hlcd_pkg::t_result i_res,
    output logic              o_in_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output hlcd_pkg::t_result o_res
);
    import hlcd_pkg::*;

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    logic    load;

    assign load = i_beat && i_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= load;
            end
        end else if (load) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_ready) begin
            r_out <= r_skid_v ? r_skid : i_res;
        end else if (load) begin
            r_skid <= i_res;
        end
    end

    assign o_in_ready = !r_skid_v;
    assign o_valid    = r_out_v;
    assign o_res      = r_out;

    `ASSERT_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `ASSERT_NEXT(a_held_beat_kept, i_clk, i_rst_n, r_out_v && !i_ready,
        r_out_v && $stable(r_out))

endmodule

>>> rtl/header_length_checksum_deframer_core.sv
// ----------------------------------------------------------------------------
// header_length_checksum_deframer_core
// Sync-header / length / checksum frame receiver with streaming payload out.
// ----------------------------------------------------------------------------
// Input stream: one beat per received byte (tuser = 0, byte in tdata) or per
// timer tick (tuser = 1). The block hunts for the three header bytes, reads a
// big-endian length and its check byte, then forwards payload bytes as they
// arrive (tlast on the final one) and ends with a good or bad checksum beat.
// Length check failures and timeout aborts after payload began also give a
// beat on the output; other input beats give none.
// Throughput: one input beat per cycle while the skid slot is empty; the
// state machine and 8-bit sums settle within the cycle of acceptance.
// Each result is registered in the output stage before it is presented.
// When the receiver stalls, results collect in the output register and one
// skid slot; s_axis_tready drops only once the skid slot holds a beat.
// Reset (synchronous, active low) returns the parser to header hunting,
// empties the output stage and loads the register defaults (headers 0,
// timeout 250 ticks). Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module header_length_checksum_deframer_core #(
    parameter int LENGTH_BITS     = hlcd_pkg::LENGTH_BITS_DEF,
    parameter int TICK_COUNT_BITS = hlcd_pkg::TICK_COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hlcd_pkg::CFG_IDX_BITS-1:0]  i_cfg_addr,
    input  logic [hlcd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // rx_byte
    input  logic [0:0]                         s_axis_tuser,  // func
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [23:0]                        m_axis_tdata,  // out_byte, frame_length
    output logic [2:0]                         m_axis_tuser,  // out_kind
    output logic                               m_axis_tlast   // out_last
);
    import hlcd_pkg::*;

    t_cfg_wr cfg;
    logic    beat;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign cfg  = '{we: i_cfg_we, addr: i_cfg_addr, data: i_cfg_data};
    assign beat = s_axis_tvalid && s_axis_tready;

    hlcd_parser #(
        .LENGTH_BITS     (LENGTH_BITS),
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_beat      (beat),
        .i_func      (s_axis_tuser[0]),
        .i_byte      (s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hlcd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_in_ready  (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {out_res.length, out_res.data};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the header / length / checksum deframer. A
// behavioral parser inside the scoreboard tracks every accepted input beat and
// queues the output beats it must cause. Each output beat is compared field by
// field in order. Directed frames cover good, bad checksum, bad length check,
// header slips and timeout aborts. Random frames then run under five register
// settings with random idling on both sides, a long output hold-off and a
// mid-run pause.
// ----------------------------------------------------------------------------
module tb_top;
    import hlcd_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 150;
    localparam int TICK_CAP      = 64;
    localparam int DRAIN_CYCLES  = 4;
    localparam logic [8:0] TK    = 9'h100;

    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_LENCHK,
        FLAW_HDR2,
        FLAW_HDR3,
        FLAW_CUT,
        FLAW_NOISE
    } t_flaw;

    class deframer_scoreboard;
        logic [7:0]  hdr_one, hdr_two, hdr_three;
        logic [15:0] timeout_lim;
        t_phase      phase;
        logic [7:0]  len_high, len_sum, pay_sum;
        logic [15:0] frame_len, rcvd, idle_ticks;
        t_result     expected_q[$];
        int          errors;
        int          kind_seen[5];

        function new();
            hdr_one     = 8'h00;
            hdr_two     = 8'h00;
            hdr_three   = 8'h00;
            timeout_lim = TIMEOUT_RESET;
            phase       = PH_HEAD1;
            len_high    = 8'h00;
            len_sum     = 8'h00;
            pay_sum     = 8'h00;
            frame_len   = 16'h0000;
            rcvd        = 16'h0000;
            idle_ticks  = 16'h0000;
            errors      = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_HEADER_ONE:   hdr_one = val[7:0];
                CFG_HEADER_TWO:   hdr_two = val[7:0];
                CFG_HEADER_THREE: hdr_three = val[7:0];
                CFG_TIMEOUT:      timeout_lim = val;
                default: ;
            endcase
        endfunction

        function void expect_beat(t_kind kind, logic [7:0] data, logic last);
            t_result r;
            r.kind   = kind;
            r.data   = data;
            r.last   = last;
            r.length = frame_len;
            expected_q.push_back(r);
        endfunction

        function void note_input(logic func, logic [7:0] b);
            logic begun;
            if (func == FUNC_TICK) begin
                if (phase == PH_HEAD1) return;
                if (idle_ticks != 16'hFFFF) idle_ticks++;
                if (idle_ticks < timeout_lim) return;
                begun = (phase == PH_DATA && rcvd != 0) || (phase == PH_SUM && frame_len != 0);
                phase = PH_HEAD1;
                idle_ticks = 16'h0000;
                if (begun) expect_beat(KIND_TIMEOUT, 8'h00, 1'b0);
                return;
            end
            idle_ticks = 16'h0000;
            case (phase)
                PH_HEAD1: if (b == hdr_one) phase = PH_HEAD2;
                PH_HEAD2: phase = (b == hdr_two) ? PH_HEAD3 : PH_HEAD1;
                PH_HEAD3: begin
                    if (b == hdr_three) begin
                        len_sum = 8'h00;
                        phase = PH_LEN1;
                    end else begin
                        phase = PH_HEAD1;
                    end
                end
                PH_LEN1: begin
                    len_high = b;
                    len_sum = len_sum + b;
                    phase = PH_LEN2;
                end
                PH_LEN2: begin
                    len_sum = len_sum + b;
                    frame_len = {len_high, b};
                    phase = PH_LENCHK;
                end
                PH_LENCHK: begin
                    if (b == len_sum) begin
                        pay_sum = 8'h00;
                        rcvd = 16'h0000;
                        phase = (frame_len == 0) ? PH_SUM : PH_DATA;
                    end else begin
                        phase = PH_HEAD1;
                        expect_beat(KIND_LEN_BAD, 8'h00, 1'b0);
                    end
                end
                PH_DATA: begin
                    pay_sum = pay_sum + b;
                    rcvd = rcvd + 16'd1;
                    if (rcvd >= frame_len) phase = PH_SUM;
                    expect_beat(KIND_PAYLOAD, b, rcvd >= frame_len);
                end
                PH_SUM: begin
                    phase = PH_HEAD1;
                    expect_beat((b == pay_sum) ? KIND_GOOD : KIND_SUM_BAD, 8'h00, 1'b0);
                end
                default: phase = PH_HEAD1;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected beat kind %0d byte %02h", got.kind, got.data));
                return;
            end
            exp = expected_q.pop_front();
            kind_seen[exp.kind]++;
            if (got.kind !== exp.kind)
                report($sformatf("kind %0d, want %0d", got.kind, exp.kind));
            if (got.data !== exp.data)
                report($sformatf("byte %02h, want %02h", got.data, exp.data));
            if (got.last !== exp.last)
                report($sformatf("last %0b, want %0b", got.last, exp.last));
            if (got.length !== exp.length)
                report($sformatf("length %04h, want %04h", got.length, exp.length));
        endtask
    endclass

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data    = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata  = 8'h00;   // rx_byte
    logic [0:0]               s_axis_tuser  = 1'b0;    // func
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [23:0]              m_axis_tdata;            // out_byte, frame_length
    logic [2:0]               m_axis_tuser;            // out_kind
    logic                     m_axis_tlast;

    deframer_scoreboard sb;
    int cycles        = 0;
    int items_sent    = 0;
    int stall_cycles  = 0;
    int rx_stall_left = 0;
    bit hold_request  = 1'b0;
    bit burst_mode    = 1'b0;

    header_length_checksum_deframer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 75) return 16'($urandom_range(1, 6));
        if (r < 95) return 16'($urandom_range(7, 40));
        return 16'($urandom_range(41, 200));
    endfunction

    function automatic t_flaw pick_flaw();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return FLAW_NONE;
        if (r < 65) return FLAW_SUM;
        if (r < 73) return FLAW_LENCHK;
        if (r < 78) return FLAW_HDR2;
        if (r < 83) return FLAW_HDR3;
        if (r < 90) return (sb.timeout_lim <= TICK_CAP) ? FLAW_CUT : FLAW_NONE;
        return FLAW_NOISE;
    endfunction

    task send_item(input logic func, input logic [7:0] b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(func, b);
        items_sent++;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task send_byte(input logic [7:0] b);
        send_item(FUNC_BYTE, b);
    endtask

    task send_tick();
        send_item(FUNC_TICK, 8'($urandom));
    endtask

    // hold inputs low until every queued beat has come out, then settle
    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task cfg_beat(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task set_config(input logic [7:0] h1, input logic [7:0] h2, input logic [7:0] h3,
                    input logic [15:0] limit);
        cfg_beat(CFG_HEADER_ONE, {8'h00, h1});
        cfg_beat(CFG_HEADER_TWO, {8'h00, h2});
        cfg_beat(CFG_HEADER_THREE, {8'h00, h3});
        cfg_beat(CFG_TIMEOUT, limit);
        i_cfg_we <= 1'b0;
    endtask

    task send_frame(input logic [15:0] len, input t_flaw flaw);
        logic [7:0] sum, chk, b;
        int n, i;
        if (flaw == FLAW_NOISE) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 3) == 0) send_tick();
                else send_byte(8'($urandom));
            end
            return;
        end
        send_byte(sb.hdr_one);
        if (flaw == FLAW_HDR2) begin
            send_byte(sb.hdr_two ^ 8'($urandom_range(1, 255)));
            return;
        end
        send_byte(sb.hdr_two);
        if (flaw == FLAW_HDR3) begin
            send_byte(sb.hdr_three ^ 8'($urandom_range(1, 255)));
            return;
        end
        send_byte(sb.hdr_three);
        chk = len[15:8] + len[7:0];
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (flaw == FLAW_LENCHK) begin
            send_byte(chk ^ 8'($urandom_range(1, 255)));
            return;
        end
        send_byte(chk);
        sum = 8'h00;
        n = int'(len);
        if (flaw == FLAW_CUT) n = (len == 0) ? 0 : $urandom_range(0, len - 1);
        for (i = 0; i < n; i++) begin
            b = 8'($urandom);
            sum = sum + b;
            if ($urandom_range(0, 49) == 0) send_tick();
            send_byte(b);
        end
        if (flaw == FLAW_CUT) begin
            repeat ((sb.timeout_lim < TICK_CAP) ? int'(sb.timeout_lim) : TICK_CAP) send_tick();
            return;
        end
        send_byte((flaw == FLAW_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum);
    endtask

    task run_random(input int count, input bit with_hold, input bit with_pause);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 9) == 0) burst_mode = !burst_mode;
            if (with_hold && items_sent - start >= 40) begin
                with_hold = 1'b0;
                burst_mode = 1'b1;
                hold_request = 1'b1;
                send_frame(16'd24, FLAW_NONE);
            end
            if (with_pause && items_sent - start >= count / 2) begin
                with_pause = 1'b0;
                drain();
            end
            send_frame(pick_len(), pick_flaw());
        end
    endtask

    // output side: random stalls, steady stretches in burst mode, one long hold
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (burst_mode) begin
                m_axis_tready <= 1'b1;
            end else begin
                if (rx_stall_left == 0 && $urandom_range(0, 4) == 0) rx_stall_left = pick_gap();
                if (rx_stall_left > 0) begin
                    m_axis_tready <= 1'b0;
                    rx_stall_left--;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result('{kind: t_kind'(m_axis_tuser), data: m_axis_tdata[7:0],
                              last: m_axis_tlast, length: m_axis_tdata[23:8]});
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && s_axis_tvalid && !s_axis_tready) stall_cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycles, sb.expected_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [8:0] directed_items[$];
        directed_items = '{
            TK,
            9'h0A5, 9'h05A, 9'h0C3, 9'h000, 9'h002, 9'h002, 9'h0FF, 9'h000, 9'h0FF,
            9'h0A5, 9'h05A, 9'h000,
            9'h0A5, 9'h05A, 9'h0C3, 9'h0FF, 9'h0FF, 9'h000,
            9'h0A5, 9'h05A, 9'h0C3, 9'h000, 9'h000, 9'h000, 9'h001,
            9'h0A5, 9'h05A, 9'h0C3, 9'h000, 9'h003, 9'h003, 9'h011, TK, TK, TK,
            9'h0A5, TK, TK, TK
        };
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(8'hA5, 8'h5A, 8'hC3, 16'd3);
        foreach (directed_items[k])
            send_item(directed_items[k][8] ? FUNC_TICK : FUNC_BYTE, directed_items[k][7:0]);
        run_random(PHASE_ITEMS, 1'b1, 1'b0);

        drain();
        set_config(8'h00, 8'h00, 8'h00, 16'd1);
        run_random(PHASE_ITEMS, 1'b0, 1'b0);

        drain();
        set_config(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        run_random(PHASE_ITEMS, 1'b0, 1'b0);

        drain();
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(2, 40)));
        run_random(PHASE_ITEMS, 1'b0, 1'b1);

        drain();
        set_config(8'h12, 8'h34, 8'h56, TIMEOUT_RESET);
        run_random(PHASE_ITEMS, 1'b0, 1'b0);

        drain();
        $display("Run covered %0d input beats: %0d payload, %0d good, %0d bad sum,",
                 items_sent, sb.kind_seen[KIND_PAYLOAD], sb.kind_seen[KIND_GOOD],
                 sb.kind_seen[KIND_SUM_BAD]);
        $display("%0d bad length, %0d aborts; input stalled %0d cycles, %0d mismatches.",
                 sb.kind_seen[KIND_LEN_BAD], sb.kind_seen[KIND_TIMEOUT], stall_cycles,
                 sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
